[hdl/pfc_pkg.sv]
`default_nettype none

package pfc_pkg;

    localparam int SYM_W = 5;
    localparam int SQ = 5;
    localparam int POS_W = 3;
    localparam int ROW_W = SQ * SYM_W;

    localparam logic [SYM_W-1:0] SYM_SPACE = 5'd26;
    localparam logic [SYM_W-1:0] SYM_X = 5'd23;

    // register indexes on the configuration port (byte address / 4)
    localparam logic [2:0] REG_DECRYPT = 3'd0;
    localparam logic [2:0] REG_ROW_0 = 3'd1;
    localparam logic [2:0] REG_ROW_1 = 3'd2;
    localparam logic [2:0] REG_ROW_2 = 3'd3;
    localparam logic [2:0] REG_ROW_3 = 3'd4;
    localparam logic [2:0] REG_ROW_4 = 3'd5;

    localparam logic [ROW_W-1:0] ROW_0_RST = 25'd13914628;
    localparam logic [ROW_W-1:0] ROW_1_RST = 25'd2130670;
    localparam logic [ROW_W-1:0] ROW_2_RST = 25'd10721443;
    localparam logic [ROW_W-1:0] ROW_3_RST = 25'd19447179;
    localparam logic [ROW_W-1:0] ROW_4_RST = 25'd27024051;

    localparam logic KIND_PASS = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_SPACE = 2'd1;
    localparam logic [1:0] BEAT_SECOND = 2'd2;

    typedef logic [SQ-1:0][ROW_W-1:0] key_sq_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] sym_a;
        logic [SYM_W-1:0] sym_b;
        logic             with_space;
        logic             last;
    } job_t;

    // last match in row-major order wins; absent letters sit at row 0, column 0
    function automatic pos_t locate(input key_sq_t key, input logic [SYM_W-1:0] sym);
        pos_t p;
        p = '0;
        for (int i = 0; i < SQ; i++) begin
            for (int j = 0; j < SQ; j++) begin
                if (key[i][SYM_W*j +: SYM_W] == sym) begin
                    p.row = POS_W'(i);
                    p.col = POS_W'(j);
                end
            end
        end
        return p;
    endfunction

    function automatic logic [SYM_W-1:0] get_cell(input key_sq_t key,
                                                  input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
        logic [SYM_W-1:0] s;
        s = '0;
        for (int i = 0; i < SQ; i++) begin
            for (int j = 0; j < SQ; j++) begin
                if (r == POS_W'(i) && c == POS_W'(j)) begin
                    s = key[i][SYM_W*j +: SYM_W];
                end
            end
        end
        return s;
    endfunction

    // one place forward (encrypt) or back (decrypt), wrapping round the square
    function automatic logic [POS_W-1:0] shift_pos(input logic [POS_W-1:0] p,
                                                   input logic decrypt);
        logic [POS_W:0] sum;
        sum = {1'b0, p} + (decrypt ? (POS_W+1)'(SQ - 1) : (POS_W+1)'(1));
        if (sum >= (POS_W+1)'(SQ)) begin
            sum = sum - (POS_W+1)'(SQ);
        end
        return sum[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/pfc_fifo.sv]
`default_nettype none

module pfc_fifo
    import pfc_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

`default_nettype wire

[hdl/pfc_front.sv]
`default_nettype none

module pfc_front
    import pfc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [SYM_W-1:0] s_in_symbol,
    input  wire logic             s_in_last,
    input  wire logic             queue_full,
    output logic                  job_push,
    output job_t                  job
);

    logic [SYM_W-1:0] pending_letter_reg, pending_letter_next;
    logic             pending_valid_reg, pending_valid_next;
    logic             space_held_reg, space_held_next;
    logic             accept, is_space, has_job;

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign is_space = (s_in_symbol == SYM_SPACE);
    assign job_push = accept && has_job;

    always_comb begin
        pending_letter_next = pending_letter_reg;
        pending_valid_next  = pending_valid_reg;
        space_held_next     = space_held_reg;
        has_job             = 1'b0;
        job.kind            = KIND_PAIR;
        job.sym_a           = pending_letter_reg;
        job.sym_b           = s_in_symbol;
        job.with_space      = space_held_reg;
        job.last            = s_in_last;

        if (!pending_valid_reg) begin
            if (is_space) begin
                has_job  = 1'b1;
                job.kind = KIND_PASS;
            end else if (s_in_last) begin
                // lone final letter: pad with X
                has_job        = 1'b1;
                job.sym_a      = s_in_symbol;
                job.sym_b      = SYM_X;
                job.with_space = 1'b0;
            end else begin
                pending_letter_next = s_in_symbol;
                pending_valid_next  = 1'b1;
                space_held_next     = 1'b0;
            end
        end else begin
            if (is_space) begin
                space_held_next = 1'b1;
                if (s_in_last) begin
                    has_job        = 1'b1;
                    job.sym_b      = SYM_X;
                    job.with_space = 1'b1;
                end
            end else begin
                has_job = 1'b1;
            end
            if (has_job) begin
                pending_letter_next = '0;
                pending_valid_next  = 1'b0;
                space_held_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
            space_held_reg     <= 1'b0;
        end else if (accept) begin
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
            space_held_reg     <= space_held_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !pending_valid_reg |-> !space_held_reg)
        else $error("space held with no letter pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_in_last) |=> !pending_valid_reg)
        else $error("letter left pending after end of message");

endmodule

`default_nettype wire

[hdl/pfc_back.sv]
`default_nettype none

module pfc_back
    import pfc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             decrypt,
    input  wire key_sq_t          key,
    input  wire logic             job_avail,
    input  wire job_t             job,
    output logic                  job_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [SYM_W-1:0]      m_out_symbol,
    output logic                  m_out_last
);

    logic             e_valid_reg, e_valid_next;
    logic             e_kind_reg;
    logic             e_space_reg;
    logic             e_last_reg;
    logic [1:0]       e_beat_reg, e_beat_next;
    pos_t             pos_a_reg, pos_b_reg;

    logic             m_valid_reg, m_valid_next;
    logic [SYM_W-1:0] m_symbol_reg;
    logic             m_last_reg;

    logic             out_free, e_fire, e_done;
    logic [SYM_W-1:0] sub_a, sub_b, beat_symbol;
    logic             beat_last;

    assign out_free = !m_valid_reg || m_ready;
    assign e_fire   = e_valid_reg && out_free;
    assign e_done   = e_fire && (e_kind_reg == KIND_PASS || e_beat_reg == BEAT_SECOND);
    assign job_pop  = job_avail && (!e_valid_reg || e_done);

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_symbol_reg;
    assign m_out_last   = m_last_reg;

    always_comb begin
        if (pos_a_reg.row == pos_b_reg.row) begin
            sub_a = get_cell(key, pos_a_reg.row, shift_pos(pos_a_reg.col, decrypt));
            sub_b = get_cell(key, pos_b_reg.row, shift_pos(pos_b_reg.col, decrypt));
        end else if (pos_a_reg.col == pos_b_reg.col) begin
            sub_a = get_cell(key, shift_pos(pos_a_reg.row, decrypt), pos_a_reg.col);
            sub_b = get_cell(key, shift_pos(pos_b_reg.row, decrypt), pos_b_reg.col);
        end else begin
            sub_a = get_cell(key, pos_a_reg.row, pos_b_reg.col);
            sub_b = get_cell(key, pos_b_reg.row, pos_a_reg.col);
        end
    end

    always_comb begin
        beat_symbol = SYM_SPACE;
        beat_last   = 1'b0;
        e_beat_next = e_beat_reg;
        if (e_kind_reg == KIND_PASS) begin
            beat_last = e_last_reg;
        end else begin
            case (e_beat_reg)
                BEAT_FIRST: begin
                    beat_symbol = sub_a;
                    e_beat_next = e_space_reg ? BEAT_SPACE : BEAT_SECOND;
                end
                BEAT_SPACE: begin
                    e_beat_next = BEAT_SECOND;
                end
                BEAT_SECOND: begin
                    beat_symbol = sub_b;
                    beat_last   = e_last_reg;
                end
                default: begin
                    e_beat_next = BEAT_SECOND;
                end
            endcase
        end
    end

    always_comb begin
        e_valid_next = e_valid_reg;
        if (job_pop) begin
            e_valid_next = 1'b1;
        end else if (e_done) begin
            e_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (e_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            e_beat_reg  <= BEAT_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            e_valid_reg <= e_valid_next;
            m_valid_reg <= m_valid_next;
            if (job_pop) begin
                e_beat_reg <= BEAT_FIRST;
            end else if (e_fire) begin
                e_beat_reg <= e_beat_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            e_kind_reg  <= job.kind;
            e_space_reg <= job.with_space;
            e_last_reg  <= job.last;
            pos_a_reg   <= locate(key, job.sym_a);
            pos_b_reg   <= locate(key, job.sym_b);
        end
        if (e_fire) begin
            m_symbol_reg <= beat_symbol;
            m_last_reg   <= beat_last;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (e_valid_reg && e_kind_reg == KIND_PAIR && e_beat_reg == BEAT_SPACE) |-> e_space_reg)
        else $error("space beat on a pair without a held space");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (e_valid_reg && e_kind_reg == KIND_PASS) |-> e_beat_reg == BEAT_FIRST)
        else $error("pass-through space advanced its beat");

endmodule

`default_nettype wire

[hdl/playfair_digraph_cipher.sv]
`default_nettype none

// Playfair digraph cipher, streaming. Each input beat carries one prepared
// symbol (letter code 0..25 with J folded to I, or 26 for a space) and a last
// flag. Letters are paired and substituted through the 5x5 key square held in
// key_row_0..4 (byte addresses 0x04..0x14, column k at bits 5k+4:5k); the
// decrypt_mode register (address 0x00) selects left/up shifts instead of
// right/down. A space with no letter pending passes straight through; the
// first space inside a pair comes out between the two substituted letters,
// further ones are dropped; a lone final letter is padded with X. Rows reset
// to the square of the key EQUINOX. The front end takes one input beat every
// cycle while its job queue (QUEUE_DEPTH entries) has room; the back end
// emits one result beat per cycle from its output register while m_ready
// allows, so a pair gives two or three result beats, a pass-through space
// one and a padded lone final letter two. Sustained, that single output
// register sets the pace, at most two result beats per input beat (a
// message of lone final letters). Between a pair's closing beat and its
// first result lie the job queue, the job registers and the output register.
// Write the registers only while the block is idle: the back end reads them
// live.

module playfair_digraph_cipher
    import pfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input symbols
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [SYM_W-1:0] s_in_symbol,
    input  wire logic             s_in_last,
    // results
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [SYM_W-1:0]      m_out_symbol,
    output logic                  m_out_last
);

    logic       decrypt_reg;
    key_sq_t    key_reg;
    logic       cfg_write;
    logic [2:0] cfg_idx;

    logic       queue_full, queue_avail, job_push, job_pop;
    job_t       push_job, pop_job;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg <= 1'b0;
            key_reg[0]  <= ROW_0_RST;
            key_reg[1]  <= ROW_1_RST;
            key_reg[2]  <= ROW_2_RST;
            key_reg[3]  <= ROW_3_RST;
            key_reg[4]  <= ROW_4_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_DECRYPT: decrypt_reg <= pwdata[0];
                REG_ROW_0:   key_reg[0]  <= pwdata[ROW_W-1:0];
                REG_ROW_1:   key_reg[1]  <= pwdata[ROW_W-1:0];
                REG_ROW_2:   key_reg[2]  <= pwdata[ROW_W-1:0];
                REG_ROW_3:   key_reg[3]  <= pwdata[ROW_W-1:0];
                REG_ROW_4:   key_reg[4]  <= pwdata[ROW_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DECRYPT: prdata = {31'b0, decrypt_reg};
            REG_ROW_0:   prdata = {7'b0, key_reg[0]};
            REG_ROW_1:   prdata = {7'b0, key_reg[1]};
            REG_ROW_2:   prdata = {7'b0, key_reg[2]};
            REG_ROW_3:   prdata = {7'b0, key_reg[3]};
            REG_ROW_4:   prdata = {7'b0, key_reg[4]};
            default:     prdata = '0;
        endcase
    end

    // front end: take beats, pair letters, queue substitution jobs
    pfc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_symbol (s_in_symbol),
        .s_in_last   (s_in_last),
        .queue_full  (queue_full),
        .job_push    (job_push),
        .job         (push_job)
    );

    // short job queue so each side can stall on its own
    pfc_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(job_t))
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .pop_data  (pop_job),
        .not_empty (queue_avail)
    );

    // back end: locate, substitute, emit one result beat per cycle while m_ready allows
    pfc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .decrypt      (decrypt_reg),
        .key          (key_reg),
        .job_avail    (queue_avail),
        .job          (pop_job),
        .job_pop      (job_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_symbol (m_out_symbol),
        .m_out_last   (m_out_last)
    );

endmodule

`default_nettype wire

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    // Settle time after the last result before a register write or the end of the run;
    // the first result of a pair passes the job queue, job registers and output register.
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;

    // A few letter codes for the directed rows.
    localparam logic [SYM_W-1:0] LTR_A = 5'd0;
    localparam logic [SYM_W-1:0] LTR_B = 5'd1;
    localparam logic [SYM_W-1:0] LTR_E = 5'd4;
    localparam logic [SYM_W-1:0] LTR_H = 5'd7;
    localparam logic [SYM_W-1:0] LTR_J = 5'd9;
    localparam logic [SYM_W-1:0] LTR_M = 5'd12;
    localparam logic [SYM_W-1:0] LTR_O = 5'd14;
    localparam logic [SYM_W-1:0] LTR_Q = 5'd16;
    localparam logic [SYM_W-1:0] LTR_S = 5'd18;
    localparam logic [SYM_W-1:0] LTR_T = 5'd19;
    localparam logic [SYM_W-1:0] LTR_Z = 5'd25;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } beat_t;

    // One directed beat; n_typed > 0 means the results are written out here
    // and the predictor is bypassed for that beat.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic [1:0]       n_typed;
        beat_t            first;
        beat_t            second;
    } directed_row_t;

    localparam beat_t NO_BEAT = '0;

    // DUT ports, all inputs driven to known values from time zero
    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [4:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [SYM_W-1:0] s_in_symbol = '0;
    logic             s_in_last = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [SYM_W-1:0] m_out_symbol;
    logic             m_out_last;

    // Predictor copy of the registers and of the pairing state
    logic             cfg_decrypt = 1'b0;
    logic [ROW_W-1:0] cfg_rows [SQ] = '{ROW_0_RST, ROW_1_RST, ROW_2_RST, ROW_3_RST, ROW_4_RST};
    logic [SYM_W-1:0] held_letter = '0;
    logic             held_valid = 1'b0;
    logic             held_space = 1'b0;

    // Square staged for the next register load
    logic [ROW_W-1:0] next_rows [SQ];

    beat_t            cipher_beats [$];
    beat_t            head_beat;
    int               mismatches = 0;
    int               cycle_count = 0;
    int               burst_left = 0;
    int               ready_mode = 0;
    int               ready_left = 0;
    int               ready_tick = 0;

    // Directed rows, default square EQUIN / OXABC / DFGHK / LMPRS / TVWYZ.
    // Typed rows sit where no letter is held, so the predictor state is untouched.
    directed_row_t directed_rows [24] = '{
        // space with nothing held passes straight through
        '{SYM_SPACE, 1'b0, 2'd1, '{SYM_SPACE, 1'b0}, NO_BEAT},
        '{SYM_SPACE, 1'b1, 2'd1, '{SYM_SPACE, 1'b1}, NO_BEAT},
        // lone final letter padded with X: E,X swap corners to Q,O
        '{LTR_E, 1'b1, 2'd2, '{LTR_Q, 1'b0}, '{LTR_O, 1'b1}},
        // same row, then same column with wrap round the bottom
        '{LTR_A, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_B, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_E, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_T, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        // rectangle with a space inside; the second space is dropped
        '{LTR_H, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{SYM_SPACE, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{SYM_SPACE, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_M, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        // identical pair takes the row rule
        '{LTR_S, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_S, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        // letters missing from the square
        '{LTR_J, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{5'd31, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        // space closing the message with a letter held
        '{5'd27, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{SYM_SPACE, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
        // final pair with a space inside
        '{5'd30, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{SYM_SPACE, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_Z, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
        // extremes of the letter range
        '{LTR_A, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_Z, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
        '{LTR_A, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
        '{SYM_SPACE, 1'b0, 2'd1, '{SYM_SPACE, 1'b0}, NO_BEAT}
    };

    playfair_digraph_cipher i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_symbol  (s_in_symbol),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_symbol (m_out_symbol),
        .m_out_last   (m_out_last)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [SYM_W-1:0] square_at(input int r, input int c);
        return cfg_rows[r][SYM_W*c +: SYM_W];
    endfunction

    // Append one expected result beat to the back of the queue.
    task automatic expect_beat(input logic [SYM_W-1:0] sym, input logic last);
        beat_t b;
        b.sym = sym;
        b.last = last;
        cipher_beats.insert(cipher_beats.size(), b);
    endtask

    // Scan the whole square so that the last match wins; a miss lands on row 0, column 0.
    task automatic find_letter(input logic [SYM_W-1:0] sym, output int r, output int c);
        r = 0;
        c = 0;
        for (int i = 0; i < SQ; i++) begin
            for (int j = 0; j < SQ; j++) begin
                if (square_at(i, j) == sym) begin
                    r = i;
                    c = j;
                end
            end
        end
    endtask

    // Substitute one digraph and queue its two or three result beats.
    task automatic substitute_pair(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b,
                                   input logic with_space, input logic last);
        int r1, c1, r2, c2, step;
        logic [SYM_W-1:0] s1, s2;
        step = cfg_decrypt ? SQ - 1 : 1;
        find_letter(a, r1, c1);
        find_letter(b, r2, c2);
        if (r1 == r2) begin
            s1 = square_at(r1, (c1 + step) % SQ);
            s2 = square_at(r2, (c2 + step) % SQ);
        end else if (c1 == c2) begin
            s1 = square_at((r1 + step) % SQ, c1);
            s2 = square_at((r2 + step) % SQ, c2);
        end else begin
            s1 = square_at(r1, c2);
            s2 = square_at(r2, c1);
        end
        expect_beat(s1, 1'b0);
        if (with_space) begin
            expect_beat(SYM_SPACE, 1'b0);
        end
        expect_beat(s2, last);
    endtask

    task automatic predict_symbol(input logic [SYM_W-1:0] sym, input logic last);
        if (!held_valid) begin
            if (sym == SYM_SPACE) begin
                expect_beat(SYM_SPACE, last);
            end else if (last) begin
                substitute_pair(sym, SYM_X, 1'b0, 1'b1);
            end else begin
                held_letter = sym;
                held_valid = 1'b1;
                held_space = 1'b0;
            end
        end else if (sym == SYM_SPACE && !last) begin
            held_space = 1'b1;
        end else begin
            if (sym == SYM_SPACE) begin
                substitute_pair(held_letter, SYM_X, 1'b1, 1'b1);
            end else begin
                substitute_pair(held_letter, sym, held_space, last);
            end
            held_letter = '0;
            held_valid = 1'b0;
            held_space = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // Setup cycle, access cycle, then release; the register takes the value
    // at the edge that closes the access cycle, so mirror it there.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_DECRYPT) begin
            cfg_decrypt = data[0];
        end else begin
            cfg_rows[idx - REG_ROW_0] = data[ROW_W-1:0];
        end
        @(posedge aclk);
    endtask

    task automatic load_config(input logic decrypt);
        apb_write(REG_DECRYPT, {31'b0, decrypt});
        for (int r = 0; r < SQ; r++) begin
            apb_write(REG_ROW_0 + 3'(r), {7'b0, next_rows[r]});
        end
    endtask

    task automatic square_default();
        next_rows = '{ROW_0_RST, ROW_1_RST, ROW_2_RST, ROW_3_RST, ROW_4_RST};
    endtask

    task automatic square_fill(input logic [ROW_W-1:0] value);
        for (int r = 0; r < SQ; r++) begin
            next_rows[r] = value;
        end
    endtask

    // Raw 25-bit rows: duplicates, missing letters and codes above 26 all turn up.
    task automatic square_arbitrary();
        for (int r = 0; r < SQ; r++) begin
            next_rows[r] = ROW_W'($urandom());
        end
    endtask

    // Proper key square: the 25 letters other than J, shuffled.
    task automatic square_shuffled();
        logic [SYM_W-1:0] codes [SQ*SQ];
        logic [SYM_W-1:0] swap;
        int n, k;
        n = 0;
        for (int code = 0; code < 26; code++) begin
            if (SYM_W'(code) != LTR_J) begin
                codes[n] = SYM_W'(code);
                n++;
            end
        end
        for (int i = SQ*SQ - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            swap = codes[i];
            codes[i] = codes[k];
            codes[k] = swap;
        end
        for (int i = 0; i < SQ*SQ; i++) begin
            next_rows[i / SQ][SYM_W*(i % SQ) +: SYM_W] = codes[i];
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one beat and hold it until taken. Bursts run back to back with
    // valid left high; at the end of a burst drop valid for a random gap.
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last,
                               input logic predicted);
        s_valid <= 1'b1;
        s_in_symbol <= sym;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        if (predicted) begin
            predict_symbol(sym, last);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
        end
    endtask

    // Drop valid and wait for every outstanding result, then let the block settle.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (cipher_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic walk_directed();
        foreach (directed_rows[k]) begin
            if (directed_rows[k].n_typed != 0) begin
                expect_beat(directed_rows[k].first.sym, directed_rows[k].first.last);
                if (directed_rows[k].n_typed == 2) begin
                    expect_beat(directed_rows[k].second.sym, directed_rows[k].second.last);
                end
            end
            send_symbol(directed_rows[k].sym, directed_rows[k].last,
                        directed_rows[k].n_typed == 0);
        end
    endtask

    // Mostly plain letters, a fair share of spaces (runs of them give the
    // dropped-space case), and now and then a code above the space.
    function automatic logic [SYM_W-1:0] pick_symbol();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
            return SYM_W'($urandom_range(0, 25));
        end else if (roll < 88) begin
            return SYM_SPACE;
        end
        return SYM_W'($urandom_range(27, 31));
    endfunction

    // Whole messages only, each closed by a last beat, so no letter is left
    // held across a register load. Hold off once mid-way until all is drained.
    task automatic run_messages(input int count);
        int sent, len;
        logic paused;
        sent = 0;
        paused = 1'b0;
        while (sent < count) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                send_symbol(pick_symbol(), k == len - 1, 1'b1);
                sent++;
            end
            if (!paused && sent >= count / 2) begin
                quiesce();
                paused = 1'b1;
            end
        end
        quiesce();
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver back-pressure: pick a stall pattern for a stretch of cycles,
    // from none at all through random and periodic to long stalls.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 80);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 2) != 0);
            2: m_ready <= ((ready_tick % 5) >= 2);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (cipher_beats.size() == 0) begin
                $display("%0t: result beat with none expected: symbol %0d last %0b",
                         $realtime, m_out_symbol, m_out_last);
                mismatches++;
            end else begin
                head_beat = cipher_beats.pop_front();
                if (m_out_symbol !== head_beat.sym) begin
                    $display("%0t: out_symbol expected %0d actual %0d",
                             $realtime, head_beat.sym, m_out_symbol);
                    mismatches++;
                end
                if (m_out_last !== head_beat.last) begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $realtime, head_beat.last, m_out_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run, reporting a mismatch, once cycle_count reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("playfair_digraph_cipher: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset square, encipher
        walk_directed();
        run_messages(30);

        // same square loaded explicitly, decipher
        square_default();
        load_config(1'b1);
        walk_directed();
        run_messages(30);

        // shuffled squares both ways
        square_shuffled();
        load_config(1'b0);
        run_messages(30);
        square_shuffled();
        load_config(1'b1);
        run_messages(30);

        // register extremes: every code 31, then every code 0
        square_fill('1);
        load_config(1'b0);
        run_messages(15);
        square_fill('0);
        load_config(1'b1);
        run_messages(15);

        // arbitrary row contents
        square_arbitrary();
        load_config(1'($urandom_range(0, 1)));
        run_messages(30);

        // back to the reset square
        square_default();
        load_config(1'b0);
        run_messages(30);

        if (mismatches == 0) begin
            $display("playfair_digraph_cipher: match");
        end else begin
            $display("playfair_digraph_cipher: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/pfc_pkg.sv
hdl/pfc_fifo.sv
hdl/pfc_front.sv
hdl/pfc_back.sv
hdl/playfair_digraph_cipher.sv
dv/tb.sv
